[rtl/ddm_pkg.sv]
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types and constants for the differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

    localparam int DUTY_W  = 8;
    localparam int CORR_W  = 9;
    localparam int WHEEL_W = 11;
    localparam int LIM_W   = 7;

    // Command codes
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_FWD   = 3'd0;
    localparam mode_t MODE_BWD   = 3'd1;
    localparam mode_t MODE_LEFT  = 3'd2;
    localparam mode_t MODE_RIGHT = 3'd3;
    localparam mode_t MODE_COAST = 3'd4;
    localparam mode_t MODE_BRAKE = 3'd5;
    localparam mode_t MODE_TICK  = 3'd6;

    // Configuration register indexes
    typedef logic cfg_idx_t;
    localparam cfg_idx_t CFG_BASE_SPEED  = 1'b0;
    localparam cfg_idx_t CFG_BRAKE_TICKS = 1'b1;

    localparam logic [DUTY_W-1:0] BASE_SPEED_RST  = 8'd255;
    localparam logic [DUTY_W-1:0] BRAKE_TICKS_RST = 8'd15;

    localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = 11'sd255;

    // floor(x / 10) = (x * 205) >> 11 for x below 1029
    localparam logic [7:0] RECIP_TENTH = 8'd205;
    localparam int         RECIP_SHIFT = 11;

    // One H-bridge channel: two direction bits and a duty magnitude
    typedef struct packed {
        logic              dir_a;
        logic              dir_b;
        logic [DUTY_W-1:0] duty;
    } chan_t;

    localparam chan_t CHAN_COAST = '{dir_a: 1'b0, dir_b: 1'b0, duty: '0};

endpackage

[rtl/ddm_wheel.sv]
// ----------------------------------------------------------------------------
// ddm_wheel
// Clamp one signed wheel command to the duty range and split it into
// direction bits and magnitude.
// ----------------------------------------------------------------------------
module ddm_wheel
    import ddm_pkg::*;
(
    input  logic signed [WHEEL_W-1:0] wheel,
    output chan_t                     chan
);

    logic signed [WHEEL_W-1:0] neg;

    assign neg = -wheel;

    always_comb
    begin
        chan = CHAN_COAST;
        if (wheel > 0)
        begin
            chan.dir_a = 1'b1;
            chan.duty  = (wheel > WHEEL_MAX) ? WHEEL_MAX[DUTY_W-1:0] : wheel[DUTY_W-1:0];
        end
        else if (wheel < 0)
        begin
            chan.dir_b = 1'b1;
            chan.duty  = (neg > WHEEL_MAX) ? WHEEL_MAX[DUTY_W-1:0] : neg[DUTY_W-1:0];
        end
    end

endmodule

[rtl/ddm_mix.sv]
// ----------------------------------------------------------------------------
// ddm_mix
// Motion mixing: pick the speed, clamp the steering correction and form
// the two encoded wheel commands.
// ----------------------------------------------------------------------------
module ddm_mix
    import ddm_pkg::*;
(
    input  mode_t                    mode,
    input  logic signed [CORR_W-1:0] correction,
    input  logic [DUTY_W-1:0]        base_speed,
    output chan_t                    left_chan,
    output chan_t                    right_chan
);

    logic [DUTY_W-1:0]         k;
    logic [DUTY_W+1:0]         k3;
    logic [DUTY_W+9:0]         prod;
    logic [LIM_W-1:0]          lim;
    logic signed [CORR_W-1:0]  lim_s;
    logic signed [CORR_W-1:0]  c;
    logic signed [WHEEL_W-1:0] ks;
    logic signed [WHEEL_W-1:0] cs;
    logic signed [WHEEL_W-1:0] left_wheel;
    logic signed [WHEEL_W-1:0] right_wheel;

    // Turns run at a quarter of the base speed
    assign k = (mode == MODE_LEFT || mode == MODE_RIGHT) ? {2'b00, base_speed[DUTY_W-1:2]}
                                                         : base_speed;

    // lim = floor(3k / 10)
    assign k3    = {1'b0, k, 1'b0} + {2'b00, k};
    assign prod  = k3 * RECIP_TENTH;
    assign lim   = prod[RECIP_SHIFT+LIM_W-1:RECIP_SHIFT];
    assign lim_s = $signed({2'b00, lim});

    always_comb
    begin
        if (correction > lim_s)
            c = lim_s;
        else if (correction < -lim_s)
            c = -lim_s;
        else
            c = correction;
    end

    assign ks = $signed({3'b000, k});
    assign cs = {{(WHEEL_W-CORR_W){c[CORR_W-1]}}, c};

    always_comb
    begin
        case (mode)
            MODE_FWD:
            begin
                left_wheel  = ks + cs;
                right_wheel = ks - cs;
            end
            MODE_BWD:
            begin
                left_wheel  = -ks + cs;
                right_wheel = -ks - cs;
            end
            MODE_LEFT:
            begin
                left_wheel  = -ks - cs;
                right_wheel = ks + cs;
            end
            MODE_RIGHT:
            begin
                left_wheel  = ks + cs;
                right_wheel = -ks - cs;
            end
            default:
            begin
                left_wheel  = '0;
                right_wheel = '0;
            end
        endcase
    end

    ddm_wheel u_left
    (
        .wheel (left_wheel),
        .chan  (left_chan)
    );

    ddm_wheel u_right
    (
        .wheel (right_wheel),
        .chan  (right_chan)
    );

endmodule

[rtl/differential_drive_mixer.sv]
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Motion command mixer driving two H-bridge channels with soft brake timer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  ------------------------------------
//  in        input      in_valid/in_stall  mode, correction
//  out       output     out_valid/out_stall left/right dir_a, dir_b, duty, braking
//  cfg       input      cfg_write          cfg_index, cfg_data
//
//  One command is taken per cycle while in_stall is low. A transfer lands
//  in the input register; when the result register is free it is mixed
//  and written to the drive word, which is also the result register, and
//  out_valid is set with it. The drive word and brake counter only advance
//  when the result register is free or being drained, so an out_stall
//  backs up into in_stall after the input register fills. Reset clears the
//  drive word (coast), the brake counter and the valid flags and loads the
//  register defaults.
//
module differential_drive_mixer
    import ddm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_write,
    input  cfg_idx_t                 cfg_index,
    input  logic [DUTY_W-1:0]        cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  mode_t                    mode,
    input  logic signed [CORR_W-1:0] correction,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     left_dir_a,
    output logic                     left_dir_b,
    output logic [DUTY_W-1:0]        left_duty,
    output logic                     right_dir_a,
    output logic                     right_dir_b,
    output logic [DUTY_W-1:0]        right_duty,
    output logic                     braking
);

    // Configuration registers
    logic [DUTY_W-1:0] base_speed_reg,  base_speed_next;
    logic [DUTY_W-1:0] brake_ticks_reg, brake_ticks_next;

    // Input register
    logic                     s1_valid_reg, s1_valid_next;
    mode_t                    s1_mode_reg,  s1_mode_next;
    logic signed [CORR_W-1:0] s1_corr_reg,  s1_corr_next;

    // Drive state, doubling as the result register
    chan_t             left_reg,  left_next;
    chan_t             right_reg, right_next;
    logic [DUTY_W-1:0] brake_rem_reg, brake_rem_next;
    logic              out_valid_reg, out_valid_next;

    logic              out_free;
    logic              s1_move;
    logic              in_take;
    logic [DUTY_W-1:0] brake_dec;
    chan_t             mix_left;
    chan_t             mix_right;
    chan_t             brake_chan;

    // Result register can take a new item when empty or draining this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    ddm_mix u_mix
    (
        .mode       (s1_mode_reg),
        .correction (s1_corr_reg),
        .base_speed (base_speed_reg),
        .left_chan  (mix_left),
        .right_chan (mix_right)
    );

    assign brake_chan = '{dir_a: 1'b1, dir_b: 1'b1,
                          duty: {1'b0, base_speed_reg[DUTY_W-1:1]}};
    assign brake_dec  = brake_rem_reg - 8'd1;

    // Configuration writes
    always_comb
    begin
        base_speed_next  = base_speed_reg;
        brake_ticks_next = brake_ticks_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE_SPEED:  base_speed_next  = cfg_data;
                CFG_BRAKE_TICKS: brake_ticks_next = cfg_data;
                default:         base_speed_next  = base_speed_reg;
            endcase
        end
    end

    // Input register: load on transfer, drop once handed on
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_mode_next  = s1_mode_reg;
        s1_corr_next  = s1_corr_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
            s1_mode_next  = mode;
            s1_corr_next  = correction;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Drive state update: one command applied per advance
    always_comb
    begin
        left_next      = left_reg;
        right_next     = right_reg;
        brake_rem_next = brake_rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
            case (s1_mode_reg)
                MODE_FWD, MODE_BWD, MODE_LEFT, MODE_RIGHT:
                begin
                    left_next      = mix_left;
                    right_next     = mix_right;
                    brake_rem_next = '0;
                end
                MODE_COAST:
                begin
                    left_next      = CHAN_COAST;
                    right_next     = CHAN_COAST;
                    brake_rem_next = '0;
                end
                MODE_BRAKE:
                begin
                    // Restart the interval; zero ticks coasts at once
                    brake_rem_next = brake_ticks_reg;
                    if (brake_ticks_reg != '0)
                    begin
                        left_next  = brake_chan;
                        right_next = brake_chan;
                    end
                    else
                    begin
                        left_next  = CHAN_COAST;
                        right_next = CHAN_COAST;
                    end
                end
                MODE_TICK:
                begin
                    if (brake_rem_reg != '0)
                    begin
                        brake_rem_next = brake_dec;
                        if (brake_dec == '0)
                        begin
                            left_next  = CHAN_COAST;
                            right_next = CHAN_COAST;
                        end
                    end
                end
                default:
                begin
                    // Unused code: hold the drive word
                    brake_rem_next = brake_rem_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg  <= BASE_SPEED_RST;
            brake_ticks_reg <= BRAKE_TICKS_RST;
            s1_valid_reg    <= 1'b0;
            left_reg        <= CHAN_COAST;
            right_reg       <= CHAN_COAST;
            brake_rem_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            base_speed_reg  <= base_speed_next;
            brake_ticks_reg <= brake_ticks_next;
            s1_valid_reg    <= s1_valid_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            brake_rem_reg   <= brake_rem_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload of the input register needs no reset
    always_ff @(posedge clk)
    begin
        s1_mode_reg <= s1_mode_next;
        s1_corr_reg <= s1_corr_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_dir_a  = left_reg.dir_a;
    assign left_dir_b  = left_reg.dir_b;
    assign left_duty   = left_reg.duty;
    assign right_dir_a = right_reg.dir_a;
    assign right_dir_b = right_reg.dir_b;
    assign right_duty  = right_reg.duty;
    assign braking     = (brake_rem_reg != '0);

    // While the brake runs both bridges short at the same duty
    a_brake_pattern : assert property (@(posedge clk) disable iff (!rst_n)
        braking |-> (left_dir_a && left_dir_b && right_dir_a && right_dir_b
                     && left_duty == right_duty))
        else $error("brake interval without matching brake drive");

    // A shorted left bridge outside the brake interval, or an unshorted one inside it, is a bad drive word
    a_short_only_braking : assert property (@(posedge clk) disable iff (!rst_n)
        (left_dir_a && left_dir_b) == braking)
        else $error("left bridge short does not match braking flag");

    // An accepted transfer is held in the input register next cycle
    a_take_lands : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted command lost before the input register");

endmodule
